// ----- rtl/wat_pkg.sv -----
// Shared types, codes and entry checks for the weekly alarm table.
package wat_pkg;

  localparam int DEFAULT_DEPTH = 16;
  localparam int COUNT_OUT_W = 5;

  typedef enum logic [2:0] {
    CMD_TICK   = 3'd0,
    CMD_ADD    = 3'd1,
    CMD_REMOVE = 3'd2,
    CMD_UPDATE = 3'd3,
    CMD_QUERY  = 3'd4
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_NOT_FOUND = 2'd2
  } status_t;

  localparam logic KIND_FIRE   = 1'b0;
  localparam logic KIND_STATUS = 1'b1;

  typedef enum logic [1:0] {
    S_IDLE,
    S_ADD,
    S_SCAN,
    S_FINISH
  } state_t;

  typedef struct packed {
    logic [7:0] id;
    logic [4:0] hour;
    logic [5:0] minute;
    logic [6:0] mask;
    logic [7:0] amount;
    logic       enabled;
    logic       executed;
  } alarm_t;

  localparam int ENTRY_W = $bits(alarm_t);

  // Control word broadcast from the sequencer to every cell.
  typedef struct packed {
    logic       start;
    logic       act;
    logic       clear;
    cmd_t       op;
    logic       found;
    logic [2:0] day;
    alarm_t     cur;
  } cell_ctl_t;

  // An entry is due on a day when it is enabled and its mask bit for that day is set.
  // Weekday seven maps onto the spare top bit, which is always clear.
  function automatic logic alarm_due(alarm_t e, logic [2:0] day);
    logic [7:0] m8;
    m8 = {1'b0, e.mask};
    return e.enabled && m8[day];
  endfunction

  function automatic logic alarm_time_eq(alarm_t e, alarm_t now);
    return (e.hour == now.hour) && (e.minute == now.minute);
  endfunction

endpackage

// ----- rtl/wat_cell.sv -----
// One table slot: holds an entry and passes the scan token to the next slot.
module wat_cell import wat_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  cell_ctl_t ctl,
  input  logic      tok_in,
  input  logic      wr,
  input  alarm_t    nxt,
  output logic      tok,
  output alarm_t    entry
);

  logic   here;
  logic   match;
  logic   due;
  logic   teq;
  alarm_t entry_next;

  always_comb begin
    here       = tok && ctl.act;
    match      = (entry.id == ctl.cur.id);
    due        = alarm_due(entry, ctl.day);
    teq        = alarm_time_eq(entry, ctl.cur);
    entry_next = entry;
    if (wr) begin
      entry_next = ctl.cur;
    end else if (here) begin
      case (ctl.op)
        CMD_TICK: begin
          if (due) begin
            entry_next.executed = teq;
          end
        end
        CMD_UPDATE: begin
          if (match && !ctl.found) begin
            entry_next = ctl.cur;
          end
        end
        CMD_REMOVE: begin
          // From the removed slot onward every slot takes its upper neighbor.
          if (match || ctl.found) begin
            entry_next = nxt;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tok <= 1'b0;
    end else if (ctl.clear) begin
      tok <= 1'b0;
    end else if (ctl.start || ctl.act) begin
      tok <= tok_in;
    end
  end

  always_ff @(posedge clk) begin
    entry <= entry_next;
  end

endmodule

// ----- rtl/wat_ctrl.sv -----
// Sequencer: takes commands, walks the token over the used slots and forms result words.
module wat_ctrl import wat_pkg::*; #(
  parameter int TABLE_DEPTH = DEFAULT_DEPTH
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cmd_valid,
  output logic                   cmd_stall,
  input  logic [2:0]             command,
  input  logic [7:0]             task_id,
  input  logic [4:0]             alarm_hour,
  input  logic [5:0]             alarm_minute,
  input  logic [6:0]             day_mask,
  input  logic [2:0]             weekday,
  input  logic [7:0]             feed_amount,
  input  logic                   enable_in,
  input  logic                   executed_in,
  input  alarm_t                 sel,
  output cell_ctl_t              ctl,
  output logic [TABLE_DEPTH-1:0] wr_sel,
  output logic                   res_valid,
  input  logic                   res_stall,
  output logic                   kind,
  output logic [1:0]             status,
  output logic [7:0]             out_id,
  output logic [4:0]             out_hour,
  output logic [5:0]             out_minute,
  output logic [6:0]             out_mask,
  output logic [7:0]             out_amount,
  output logic                   out_enabled,
  output logic                   out_executed,
  output logic [COUNT_OUT_W-1:0] entry_count,
  output logic                   last
);

  localparam int CW = $clog2(TABLE_DEPTH + 1);

  state_t       state, state_next;
  cmd_t         op, op_next;
  alarm_t       cur, cur_next;
  logic [2:0]   day, day_next;
  logic [CW-1:0] count, count_next;
  logic [CW-1:0] pos, pos_next;
  logic         found, found_next;
  status_t      cmd_status, cmd_status_next;
  alarm_t       qentry, qentry_next;
  alarm_t       pend, pend_next;
  logic         pend_v, pend_v_next;

  logic         res_valid_next;
  logic         res_kind, res_kind_next;
  status_t      res_status, res_status_next;
  alarm_t       res_entry, res_entry_next;
  logic [CW-1:0] res_count, res_count_next;
  logic         res_last, res_last_next;

  logic start, act, clear, add_we;
  logic slot_free, match, fire, hold, hit;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      pend_v    <= 1'b0;
      res_valid <= 1'b0;
    end else begin
      state     <= state_next;
      count     <= count_next;
      pend_v    <= pend_v_next;
      res_valid <= res_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    op         <= op_next;
    cur        <= cur_next;
    day        <= day_next;
    pos        <= pos_next;
    found      <= found_next;
    cmd_status <= cmd_status_next;
    qentry     <= qentry_next;
    pend       <= pend_next;
    res_kind   <= res_kind_next;
    res_status <= res_status_next;
    res_entry  <= res_entry_next;
    res_count  <= res_count_next;
    res_last   <= res_last_next;
  end

  always_comb begin
    state_next      = state;
    op_next         = op;
    cur_next        = cur;
    day_next        = day;
    count_next      = count;
    pos_next        = pos;
    found_next      = found;
    cmd_status_next = cmd_status;
    qentry_next     = qentry;
    pend_next       = pend;
    pend_v_next     = pend_v;
    res_valid_next  = res_valid;
    res_kind_next   = res_kind;
    res_status_next = res_status;
    res_entry_next  = res_entry;
    res_count_next  = res_count;
    res_last_next   = res_last;
    start     = 1'b0;
    act       = 1'b0;
    clear     = 1'b0;
    add_we    = 1'b0;
    cmd_stall = (state != S_IDLE);
    slot_free = !res_valid || !res_stall;
    match     = (sel.id == cur.id);
    fire      = alarm_due(sel, day) && alarm_time_eq(sel, cur) && !sel.executed;
    hit       = match || found;
    hold      = (op == CMD_TICK) && fire && pend_v && !slot_free;

    if (res_valid && !res_stall) begin
      res_valid_next = 1'b0;
    end

    case (state)
      S_IDLE: begin
        if (cmd_valid) begin
          cur_next   = '{id: task_id, hour: alarm_hour, minute: alarm_minute,
                         mask: day_mask, amount: feed_amount,
                         enabled: enable_in, executed: executed_in};
          day_next   = weekday;
          found_next = 1'b0;
          case (command)
            CMD_ADD: begin
              op_next    = CMD_ADD;
              state_next = S_ADD;
            end
            CMD_TICK, CMD_REMOVE, CMD_UPDATE, CMD_QUERY: begin
              op_next = cmd_t'(command);
              if (count == '0) begin
                cmd_status_next = ST_NOT_FOUND;
                state_next      = S_FINISH;
              end else begin
                start      = 1'b1;
                pos_next   = '0;
                state_next = S_SCAN;
              end
            end
            default: begin
            end
          endcase
        end
      end
      S_ADD: begin
        if (count < CW'(TABLE_DEPTH)) begin
          add_we          = 1'b1;
          count_next      = count + CW'(1);
          cmd_status_next = ST_OK;
        end else begin
          cmd_status_next = ST_FULL;
        end
        state_next = S_FINISH;
      end
      S_SCAN: begin
        if (!hold) begin
          act = 1'b1;
          if (op == CMD_TICK && fire) begin
            // A fired entry is held in pend until the next one fires or the walk ends, so the final one can carry last.
            if (pend_v) begin
              res_valid_next  = 1'b1;
              res_kind_next   = KIND_FIRE;
              res_status_next = ST_OK;
              res_entry_next  = pend;
              res_count_next  = count;
              res_last_next   = 1'b0;
            end
            pend_next          = sel;
            pend_next.executed = 1'b1;
            pend_v_next        = 1'b1;
          end
          if (op == CMD_QUERY && match && !found) begin
            qentry_next = sel;
          end
          found_next = hit;
          pos_next   = pos + CW'(1);
          if (pos == count - CW'(1)) begin
            clear           = 1'b1;
            state_next      = S_FINISH;
            cmd_status_next = hit ? ST_OK : ST_NOT_FOUND;
            if (op == CMD_REMOVE && hit) begin
              count_next = count - CW'(1);
            end
          end
        end
      end
      S_FINISH: begin
        if (slot_free) begin
          state_next     = S_IDLE;
          res_count_next = count;
          res_last_next  = 1'b1;
          case (op)
            CMD_TICK: begin
              if (pend_v) begin
                res_valid_next  = 1'b1;
                res_kind_next   = KIND_FIRE;
                res_status_next = ST_OK;
                res_entry_next  = pend;
                pend_v_next     = 1'b0;
              end
            end
            CMD_QUERY: begin
              res_valid_next  = 1'b1;
              res_kind_next   = KIND_STATUS;
              res_status_next = cmd_status;
              res_entry_next  = (cmd_status == ST_OK) ? qentry : '0;
            end
            default: begin
              res_valid_next  = 1'b1;
              res_kind_next   = KIND_STATUS;
              res_status_next = cmd_status;
              res_entry_next  = '0;
            end
          endcase
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_comb begin
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      wr_sel[i] = add_we && (count == CW'(i));
    end
  end

  assign ctl = '{start: start, act: act, clear: clear, op: op, found: found,
                 day: day, cur: cur};

  assign kind         = res_kind;
  assign status       = res_status;
  assign out_id       = res_entry.id;
  assign out_hour     = res_entry.hour;
  assign out_minute   = res_entry.minute;
  assign out_mask     = res_entry.mask;
  assign out_amount   = res_entry.amount;
  assign out_enabled  = res_entry.enabled;
  assign out_executed = res_entry.executed;
  assign entry_count  = COUNT_OUT_W'(res_count);
  assign last         = res_last;

endmodule

// ----- rtl/weekly_alarm_table.sv -----
// Top level of the weekly alarm table: a row of entry slots and their sequencer.
//
//   channel | valid     | stall     | payload
//   --------+-----------+-----------+------------------------------------------------
//   command | cmd_valid | cmd_stall | command, task_id, alarm_hour, alarm_minute,
//           |           |           | day_mask, weekday, feed_amount, enable_in,
//           |           |           | executed_in
//   result  | res_valid | res_stall | kind, status, out_id .. out_executed,
//           |           |           | entry_count, last
//
// Tick, remove, update and query walk a token over the used slots one per cycle (an empty
// table skips the walk); add writes the next free slot, or reports full when none is left.
// A tick holds its walk while a fired word cannot move into a stalled output register.
// One command is in flight at a time; cmd_stall is high until its last word, if any, is registered.
// Reset empties the table at once; slots are not cleared and hold stale data until written.
module weekly_alarm_table import wat_pkg::*; #(
  parameter int TABLE_DEPTH = DEFAULT_DEPTH
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cmd_valid,
  output logic                   cmd_stall,
  input  logic [2:0]             command,
  input  logic [7:0]             task_id,
  input  logic [4:0]             alarm_hour,
  input  logic [5:0]             alarm_minute,
  input  logic [6:0]             day_mask,
  input  logic [2:0]             weekday,
  input  logic [7:0]             feed_amount,
  input  logic                   enable_in,
  input  logic                   executed_in,
  output logic                   res_valid,
  input  logic                   res_stall,
  output logic                   kind,
  output logic [1:0]             status,
  output logic [7:0]             out_id,
  output logic [4:0]             out_hour,
  output logic [5:0]             out_minute,
  output logic [6:0]             out_mask,
  output logic [7:0]             out_amount,
  output logic                   out_enabled,
  output logic                   out_executed,
  output logic [COUNT_OUT_W-1:0] entry_count,
  output logic                   last
);

  cell_ctl_t              ctl;
  logic [TABLE_DEPTH-1:0] wr_sel;
  logic [TABLE_DEPTH-1:0] tok;
  alarm_t                 ent [TABLE_DEPTH];
  alarm_t                 nxt [TABLE_DEPTH];
  logic [ENTRY_W-1:0]     sel_bits;

  // The token is one-hot, so the slot under it is picked by a plain and-or.
  always_comb begin
    sel_bits = '0;
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      if (tok[i]) begin
        sel_bits = sel_bits | ent[i];
      end
    end
  end

  for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
    if (i == TABLE_DEPTH - 1) begin : g_end
      assign nxt[i] = ent[i];
    end else begin : g_mid
      assign nxt[i] = ent[i+1];
    end

    if (i == 0) begin : g_head
      wat_cell u_cell (
        .clk    (clk),
        .rst    (rst),
        .ctl    (ctl),
        .tok_in (ctl.start),
        .wr     (wr_sel[i]),
        .nxt    (nxt[i]),
        .tok    (tok[i]),
        .entry  (ent[i])
      );
    end else begin : g_body
      wat_cell u_cell (
        .clk    (clk),
        .rst    (rst),
        .ctl    (ctl),
        .tok_in (tok[i-1]),
        .wr     (wr_sel[i]),
        .nxt    (nxt[i]),
        .tok    (tok[i]),
        .entry  (ent[i])
      );
    end
  end

  wat_ctrl #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .cmd_valid    (cmd_valid),
    .cmd_stall    (cmd_stall),
    .command      (command),
    .task_id      (task_id),
    .alarm_hour   (alarm_hour),
    .alarm_minute (alarm_minute),
    .day_mask     (day_mask),
    .weekday      (weekday),
    .feed_amount  (feed_amount),
    .enable_in    (enable_in),
    .executed_in  (executed_in),
    .sel          (alarm_t'(sel_bits)),
    .ctl          (ctl),
    .wr_sel       (wr_sel),
    .res_valid    (res_valid),
    .res_stall    (res_stall),
    .kind         (kind),
    .status       (status),
    .out_id       (out_id),
    .out_hour     (out_hour),
    .out_minute   (out_minute),
    .out_mask     (out_mask),
    .out_amount   (out_amount),
    .out_enabled  (out_enabled),
    .out_executed (out_executed),
    .entry_count  (entry_count),
    .last         (last)
  );

endmodule
